@@ rtl/cif_pkg.sv @@
// Shared constants for the covered interval finder.
// Item kinds, register indexes and coordinate widths; no dependencies.
`default_nettype none

package cif_pkg;

	localparam int COORD_W = 31;
	localparam logic [COORD_W-1:0] COORD_MAX = 31'h7FFF_FFFF;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_COVERAGE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_START    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WIN_LEN      = 2'd2;

	localparam int MINCOV_W = 16;
	localparam int WINLEN_W = 13;

endpackage

`default_nettype wire

@@ rtl/cif_count_ram.sv @@
// Coverage count store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module cif_count_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/covered_interval_finder_core.sv @@
// Covered interval finder top level: per-position coverage counts over a window.
// Uses cif_pkg and cif_count_ram.
//
// Input channel s_*: one transaction per item. s_tuser carries the kind
// (clear, add read interval, query); s_tdata carries read_start and read_end.
// Output channel m_*: one transaction per query. m_tuser is found; m_tdata
// carries interval_start and interval_end (both zero when found is 0).
// Config port cfg_*: single-cycle writes; the user keeps them to idle (not enforced).
// Timing: all work runs through the count RAM at one position per cycle.
//   clear : accept, then a sweep writing zeros to all MAX_WINDOW positions.
//   add   : accept, clip to the window and form offsets, then read, increment
//           and write each clipped position (none when the clipped read is empty).
//   query : reads positions from the scan pointer until a covered run ends
//           or the window end is reached, then hands the result to the output.
//   kind 3: accepted, no effect.
// After reset the block runs the same clearing sweep over all positions before
// s_tready rises. A finished query result waits in the output register; the
// block keeps accepting items meanwhile and stalls only when a second result
// is ready while the first is still not taken.
`default_nettype none

module covered_interval_finder_core #(
	parameter int MAX_WINDOW = 4096,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// config
	input  wire logic                               cfg_we,
	input  wire logic [cif_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [cif_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// input items
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [63:0]                        s_tdata,   // read_start, read_end
	input  wire logic [cif_pkg::KIND_W-1:0]         s_tuser,   // kind
	// results
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [63:0]                             m_tdata,   // interval_start, interval_end
	output logic                                    m_tuser    // found
);

	import cif_pkg::*;

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CLIP  = 3'd2;
	localparam logic [2:0] ST_OFFS  = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]            state_q;
	logic [MINCOV_W-1:0]   min_cov_q;
	logic [COORD_W-1:0]    win_start_q;
	logic [WINLEN_W-1:0]   win_len_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      sp_q;
	logic [LEN_W-1:0]      ptr_q;
	logic [LEN_W-1:0]      end_q;
	logic [AW-1:0]         clr_q;
	logic [COORD_W-1:0]    rs_q;
	logic [COORD_W-1:0]    re_q;
	logic                  phase_q;
	logic [LEN_W-1:0]      run_start_q;
	logic                  res_found_q;
	logic [LEN_W-1:0]      res_start_q;
	logic [LEN_W-1:0]      res_end_q;
	logic                  vld_s1;
	logic [AW-1:0]         addr_s1;
	logic                  m_tvalid_q;
	logic [63:0]           m_tdata_q;
	logic                  m_tuser_q;

	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] inc_data;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic                  rd_en;
	logic                  covered;
	logic [COORD_W-1:0]    room;
	logic [31:0]           len32;
	logic [COORD_W-1:0]    win_end;
	logic                  out_free;
	logic                  s_acc;

	// effective window length
	always_comb begin
		room  = COORD_MAX - win_start_q;
		len32 = 32'(win_len_q);
		if (len32 > 32'(MAX_WINDOW)) begin
			len32 = 32'(MAX_WINDOW);
		end
		if (len32 > 32'(room)) begin
			len32 = 32'(room);
		end
	end

	assign win_end  = win_start_q + COORD_W'(len_q);
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign inc_data = (32'(rd_data) == COUNT_MAX32) ? rd_data : rd_data + 1'b1;
	assign covered  = 32'(rd_data) >= 32'(min_cov_q);

	always_comb begin
		rd_en = 1'b0;
		if (state_q == ST_ADD) begin
			rd_en = ptr_q < end_q;
		end else if (state_q == ST_SCAN) begin
			rd_en = ptr_q < len_q;
		end
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_ADD) && vld_s1;
			ram_waddr = addr_s1;
			ram_wdata = inc_data;
		end
	end

	cif_count_ram #(
		.DEPTH(MAX_WINDOW),
		.AW   (AW),
		.DW   (COUNT_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	// config registers and effective length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cov_q   <= MINCOV_W'(1);
			win_start_q <= '0;
			win_len_q   <= WINLEN_W'(4096);
			len_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MIN_COVERAGE: min_cov_q   <= cfg_wdata[MINCOV_W-1:0];
					REG_WIN_START:    win_start_q <= cfg_wdata[COORD_W-1:0];
					REG_WIN_LEN:      win_len_q   <= cfg_wdata[WINLEN_W-1:0];
					default: ;
				endcase
			end
			len_q <= len32[LEN_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			sp_q        <= '0;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			phase_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1  <= rd_en;
			addr_s1 <= ptr_q[AW-1:0];
			if (rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_WINDOW - 1)) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						rs_q    <= s_tdata[COORD_W-1:0];
						re_q    <= s_tdata[2*COORD_W-1:COORD_W];
						ptr_q   <= sp_q;
						phase_q <= 1'b0;
						unique case (s_tuser)
							KIND_CLEAR: begin
								sp_q    <= '0;
								state_q <= ST_CLR;
							end
							KIND_ADD:   state_q <= ST_CLIP;
							KIND_QUERY: state_q <= ST_SCAN;
							default: ;
						endcase
					end
				end
				ST_CLIP: begin
					rs_q <= (rs_q > win_start_q) ? rs_q : win_start_q;
					re_q <= (re_q < win_end) ? re_q : win_end;
					state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					ptr_q <= LEN_W'(rs_q - win_start_q);
					end_q <= LEN_W'(re_q - win_start_q);
					state_q <= (rs_q < re_q) ? ST_ADD : ST_IDLE;
				end
				ST_ADD: begin
					if (!rd_en && !vld_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (vld_s1 && !phase_q && covered) begin
						phase_q     <= 1'b1;
						run_start_q <= LEN_W'(addr_s1);
					end else if (vld_s1 && phase_q && !covered) begin
						res_found_q <= 1'b1;
						res_start_q <= run_start_q;
						res_end_q   <= LEN_W'(addr_s1);
						sp_q        <= LEN_W'(addr_s1);
						vld_s1      <= 1'b0;
						state_q     <= ST_OUT;
					end else if (!vld_s1 && !rd_en) begin
						res_found_q <= phase_q;
						res_start_q <= run_start_q;
						res_end_q   <= len_q;
						if (phase_q || sp_q < len_q) begin
							sp_q <= len_q;
						end
						vld_s1  <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tuser_q <= res_found_q;
			if (res_found_q) begin
				m_tdata_q <= {2'b00,
					win_start_q + COORD_W'(res_end_q),
					win_start_q + COORD_W'(res_start_q)};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire
